// File: src/dictionary_charset_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// dictionary charset decoder assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef DICTIONARY_CHARSET_DECODER_UNIT_DEFINES_SVH
`define DICTIONARY_CHARSET_DECODER_UNIT_DEFINES_SVH

// property checked only outside reset
`define DCD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dcd assertion failed");

// property checked on every edge, reset included
`define DCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dcd assertion failed");

`endif

// File: src/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// types, constants and mapping functions of the dictionary charset decoder
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam logic [7:0]  LEAD_TWO   = 8'hA0;
  localparam logic [7:0]  LEAD_THREE = 8'hF6;
  localparam logic [7:0]  LEAD_FOUR  = 8'hFC;
  localparam logic [15:0] REMAP_BASE = 16'h0203;
  localparam logic [15:0] REMAP_SPAN = 16'h0041;
  localparam logic [15:0] ROW_OFFSET = 16'h5EDF;
  localparam logic [15:0] ROW_SIZE   = 16'h00BE;
  localparam logic [7:0]  COL_WRAP   = 8'h5E;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BAD   = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  typedef enum logic [1:0] {
    ESC_NORMAL,
    ESC_FIRST,
    ESC_COPY
  } esc_phase_t;

  typedef struct packed {
    logic [1:0]       pending;
    logic [7:0]       partial;
    logic             ref_mode;
    esc_phase_t       esc;
    logic [2:0][15:0] hist;
    logic [1:0]       fill;
    logic             err_latched;
  } dcd_state_t;

  typedef struct packed {
    logic        produce;
    logic [15:0] code_point;
    logic        point_valid;
    logic [1:0]  error_code;
  } dcd_result_t;

  localparam dcd_state_t STATE_RESET = '{
    pending: 2'd0, partial: 8'd0, ref_mode: 1'b0, esc: ESC_NORMAL,
    hist: '0, fill: 2'd0, err_latched: 1'b0
  };

  localparam logic [15:0] REMAP_TABLE [66] = '{
    16'h2992, 16'h2694, 16'h0000, 16'h0294, 16'h00AE, 16'h2655, 16'h26AE, 16'h26AD,
    16'h007E, 16'h0000, 16'h020D, 16'h020E, 16'h020F, 16'h0210, 16'h00E6, 16'h00E7,
    16'h00F0, 16'h00F8, 16'h0127, 16'h014B, 16'h0153, 16'h03B2, 16'h03B8, 16'h0111,
    16'h0180, 16'h021C, 16'h0195, 16'h021E, 16'h021F, 16'h0220, 16'h0061, 16'h0062,
    16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067, 16'h0068, 16'h0069, 16'h006A,
    16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F, 16'h0070, 16'h0071, 16'h0072,
    16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077, 16'h0078, 16'h0079, 16'h007A,
    16'h023B, 16'h023C, 16'h023D, 16'h023E, 16'h023F, 16'h0240, 16'h0241, 16'h0242,
    16'h0152, 16'h0153
  };

  localparam logic [15:0] CP1252_HIGH [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  // windows-1252 upper control range, holes map to themselves
  function automatic logic [15:0] cp1252(input logic [7:0] b);
    if (b[7:5] == 3'b100) begin
      return CP1252_HIGH[b[4:0]];
    end
    return {8'h00, b};
  endfunction

  function automatic logic [15:0] remap(input logic [15:0] ch);
    logic [15:0] diff;
    diff = ch - REMAP_BASE;
    if (ch == 16'h25FF) return 16'h00A0;
    if (ch == 16'h25FE) return 16'h2012;
    if (ch == 16'h25FD) return 16'h2014;
    if (diff <= REMAP_SPAN) return REMAP_TABLE[diff[6:0]];
    if (ch == 16'h036E) return 16'h035C;
    if (ch == 16'h036F) return 16'h0000;
    return ch;
  endfunction

  function automatic logic [15:0] finish_map(input logic [15:0] ch);
    logic [15:0] r;
    r = remap(ch);
    if (r[15:8] == 8'h00) begin
      return cp1252(r[7:0]);
    end
    return r;
  endfunction

  // row/column arithmetic of a two-byte code
  function automatic logic [15:0] decode_pair(input logic [7:0] lead,
                                              input logic [7:0] b);
    logic [7:0]  col;
    logic [15:0] sum;
    logic [15:0] prod;
    col = b - 8'h21;
    if (col > COL_WRAP) col = col - 8'h21;
    sum  = {lead, b} + ROW_OFFSET;
    prod = ROW_SIZE * {8'h00, sum[15:8]};
    if (lead == LEAD_TWO) return {8'h00, b};
    return prod + {8'h00, col} + 16'h0100;
  endfunction

endpackage

// File: src/dictionary_charset_decoder_unit.sv
// ----------------------------------------------------------------------------
// dictionary_charset_decoder_unit
// byte stream of the dictionary charset in, unicode code points out
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle and gives at most one result beat per byte.
// An input register holds the byte, the decode (row/column arithmetic with
// one constant multiply, the remap table, the windows-1252 map and the
// history checks) runs between that register and the result register, and
// the string state is updated in the same cycle.
// Throughput is one byte per clock; the only stall comes from the result
// side holding result_ready low while a result is waiting. Bytes that give
// no result (lead bytes, dropped zero codes, bytes after an error) leave the
// block without a beat. The last byte of a string always gives one result
// with end_of_string set and returns the string state to its reset value.
module dictionary_charset_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_of_string,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] code_point,
  output logic        point_valid,
  output logic [1:0]  error_code,
  output logic        end_of_string
);
  import dcd_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // string state
  dcd_state_t  st;
  dcd_state_t  st_next;
  dcd_result_t res;

  // result register moves whenever a byte waits and it is empty or being drained
  logic advance;

  assign advance    = in_valid && (!result_valid || result_ready);
  assign item_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_byte <= byte_value;
      in_last <= last_of_string;
    end
  end

  dcd_step u_step (
    .st             (st),
    .byte_value     (in_byte),
    .last_of_string (in_last),
    .st_next        (st_next),
    .res            (res)
  );

  // state follows each byte as it leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res.produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.produce) begin
      code_point    <= res.code_point;
      point_valid   <= res.point_valid;
      error_code    <= res.error_code;
      end_of_string <= in_last;
    end
  end

endmodule

// File: src/dcd_step.sv
// ----------------------------------------------------------------------------
// dcd_step
// per-byte decode: next string state and the result of one byte
// ----------------------------------------------------------------------------
module dcd_step (
  input  dcd_pkg::dcd_state_t  st,
  input  logic [7:0]           byte_value,
  input  logic                 last_of_string,
  output dcd_pkg::dcd_state_t  st_next,
  output dcd_pkg::dcd_result_t res
);
  import dcd_pkg::*;

  logic [15:0] cp;
  logic [15:0] code;
  logic [1:0]  err;
  logic        have;
  logic        do_accept;
  logic        do_push;
  logic [15:0] push_val;

  always_comb begin
    st_next   = st;
    cp        = 16'h0000;
    code      = 16'h0000;
    err       = ERR_NONE;
    have      = 1'b0;
    do_accept = 1'b0;
    do_push   = 1'b0;
    push_val  = 16'h0000;

    if (st.err_latched) begin
      // bytes ignored until the string closes
    end else if (st.esc == ESC_FIRST) begin
      if (byte_value == 8'h25) begin
        cp          = 16'h0025;
        st_next.esc = ESC_NORMAL;
      end else begin
        cp          = cp1252(byte_value);
        st_next.esc = ESC_COPY;
      end
      do_push  = 1'b1;
      push_val = cp;
      have     = 1'b1;
    end else if (st.esc == ESC_COPY) begin
      cp       = cp1252(byte_value);
      do_push  = 1'b1;
      push_val = cp;
      have     = 1'b1;
      if (byte_value == 8'h0A) st_next.esc = ESC_NORMAL;
    end else if (st.pending != 2'd0) begin
      st_next.pending = st.pending - 2'd1;
      if (st.pending == 2'd1) begin
        if (st.partial >= LEAD_THREE) begin
          err = ERR_BAD;
        end else begin
          code      = finish_map(decode_pair(st.partial, byte_value));
          do_accept = 1'b1;
        end
      end
    end else if (st.ref_mode) begin
      code      = {8'h00, byte_value};
      do_accept = 1'b1;
    end else if (byte_value >= LEAD_TWO) begin
      st_next.partial = byte_value;
      if (byte_value >= LEAD_FOUR) begin
        st_next.pending = 2'd3;
      end else if (byte_value >= LEAD_THREE) begin
        st_next.pending = 2'd2;
      end else begin
        st_next.pending = 2'd1;
      end
    end else begin
      code      = finish_map({8'h00, byte_value});
      do_accept = 1'b1;
    end

    // main codes of zero are dropped
    if (do_accept && code != 16'h0000) begin
      do_push  = 1'b1;
      push_val = code;
      cp       = code;
      have     = 1'b1;
    end

    if (do_push) begin
      st_next.hist[2] = st.hist[1];
      st_next.hist[1] = st.hist[0];
      st_next.hist[0] = push_val;
      if (st.fill != 2'd3) st_next.fill = st.fill + 2'd1;
    end

    // history checks after each complete main code
    if (do_accept) begin
      if (st_next.fill >= 2'd1 && st_next.hist[0] == 16'h007D) begin
        st_next.ref_mode = 1'b0;
      end
      if (st_next.fill == 2'd3 && st_next.hist[2] == 16'h005C &&
          (st_next.hist[1] == 16'h0053 || st_next.hist[1] == 16'h0077) &&
          st_next.hist[0] == 16'h007B) begin
        st_next.ref_mode = 1'b1;
      end
      if (st_next.fill >= 2'd2 && st_next.hist[1] == 16'h0040 &&
          st_next.hist[0] == 16'h0043) begin
        st_next.esc = ESC_FIRST;
      end
    end

    if (!st.err_latched && last_of_string && err == ERR_NONE &&
        (st_next.pending != 2'd0 || st_next.esc == ESC_FIRST)) begin
      err = ERR_TRUNC;
    end
    if (err != ERR_NONE) begin
      have                = 1'b0;
      st_next.err_latched = 1'b1;
    end
    if (!have) cp = 16'h0000;

    if (last_of_string) st_next = STATE_RESET;

    res.produce     = last_of_string || have || (err != ERR_NONE);
    res.code_point  = cp;
    res.point_valid = have;
    res.error_code  = err;
  end

endmodule

// File: src/dcd_checker.sv
// ----------------------------------------------------------------------------
// dcd_checker
// port-level checks of the dictionary charset decoder
// ----------------------------------------------------------------------------
`include "dictionary_charset_decoder_unit_defines.svh"

module dcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] code_point,
  input logic        point_valid,
  input logic [1:0]  error_code,
  input logic        end_of_string
);
  import dcd_pkg::*;

  // result beat waiting on the receiver
  logic        stalled;
  logic [19:0] beat_bits;

  assign stalled   = result_valid && !result_ready;
  assign beat_bits = {code_point, point_valid, error_code, end_of_string};

  // nothing emerges straight after reset
  `DCD_ASSERT_ALWAYS(a_idle_after_rst, clk, rst |=> !result_valid)

  // an error beat never carries a character
  `DCD_ASSERT(a_err_no_point, clk, rst, (result_valid && error_code != ERR_NONE) |-> !point_valid)

  // a dropped point reads as zero
  `DCD_ASSERT(a_no_point_zero, clk, rst, (result_valid && !point_valid) |-> code_point == 16'h0000)

  // a stalled result beat holds
  `DCD_ASSERT(a_result_hold, clk, rst, stalled |=> (result_valid && $stable(beat_bits)))

endmodule

bind dictionary_charset_decoder_unit dcd_checker u_dcd_checker (.*);
